// File: rtl/core/hbfd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Heartbeat failure detector package
// Shared widths, action and register codes, and the control structs that
// pass between the controller, the datapath and the register block.
// ---------------------------------------------------------------------------
package hbfd_pkg;

  // Default sizes of the slot table.
  localparam int NODES_DEF   = 16;
  localparam int ID_BITS_DEF = 8;

  // Fixed field widths.
  localparam int TIME_W  = 32;
  localparam int NC_W    = 5;
  localparam int INT_W   = 16;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Action codes of an input item.
  localparam logic [1:0] ACT_TICK      = 2'd0;
  localparam logic [1:0] ACT_HEARTBEAT = 2'd1;
  localparam logic [1:0] ACT_ASSIGN    = 2'd2;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_ENABLE    = 2'd0;
  localparam logic [1:0] REG_NODE_CNT  = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_INTERVAL  = 2'd3;

  // Current register values.
  typedef struct packed {
    logic              enable;
    logic [NC_W-1:0]   node_count;
    logic [TIME_W-1:0] threshold;
    logic [INT_W-1:0]  interval;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tick;
    logic assign_w;
    logic hb_load;
    logic walk_start;
    logic walking;
    logic scan_mode;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_due;
    logic walk_done;
    logic hb_hit;
  } dp_stat_t;

endpackage

// File: rtl/core/hbfd_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Heartbeat failure detector configuration registers
// APB-style register block holding enable, node count, dead threshold and
// scan interval.
// ---------------------------------------------------------------------------
module hbfd_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hbfd_pkg::PADDR_W-1:0] paddr,
  input  logic [hbfd_pkg::PDATA_W-1:0] pwdata,
  output logic [hbfd_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output hbfd_pkg::cfg_t               cfg
);
  import hbfd_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  // Register writes at the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable     <= 1'b0;
      cfg_r.node_count <= NC_W'(16);
      cfg_r.threshold  <= TIME_W'(3000);
      cfg_r.interval   <= INT_W'(1000);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ENABLE:    cfg_r.enable     <= pwdata[0];
        REG_NODE_CNT:  cfg_r.node_count <= pwdata[NC_W-1:0];
        REG_THRESHOLD: cfg_r.threshold  <= pwdata[TIME_W-1:0];
        REG_INTERVAL:  cfg_r.interval   <= pwdata[INT_W-1:0];
        default:       cfg_r.enable     <= cfg_r.enable;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (reg_idx)
      REG_ENABLE:    prdata = PDATA_W'(cfg_r.enable);
      REG_NODE_CNT:  prdata = PDATA_W'(cfg_r.node_count);
      REG_THRESHOLD: prdata = PDATA_W'(cfg_r.threshold);
      REG_INTERVAL:  prdata = PDATA_W'(cfg_r.interval);
      default:       prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/hbfd_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Heartbeat failure detector controller
// Decodes accepted items and sequences the slot walk used by heartbeats and
// scans.
// ---------------------------------------------------------------------------
module hbfd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_action,
  input  hbfd_pkg::dp_stat_t stat,
  output logic               busy,
  output hbfd_pkg::dp_cmd_t  cmd
);
  import hbfd_pkg::*;

  typedef enum logic {S_IDLE, S_WALK} state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   scan_mode_r, scan_mode_nxt;
  logic   accept, is_tick, is_hb, is_assign, go_walk;

  assign accept    = start && !busy_r;
  assign is_tick   = accept && (in_action == ACT_TICK);
  assign is_hb     = accept && (in_action == ACT_HEARTBEAT);
  assign is_assign = accept && (in_action == ACT_ASSIGN);
  assign go_walk   = is_hb || (is_tick && stat.scan_due);

  // Next state: a walk ends when the table is exhausted or a heartbeat matched.
  always_comb begin
    state_nxt     = state_r;
    scan_mode_nxt = scan_mode_r;
    unique case (state_r)
      S_IDLE: begin
        if (go_walk) begin
          state_nxt     = S_WALK;
          scan_mode_nxt = is_tick;
        end
      end
      S_WALK: begin
        if (stat.walk_done || (!scan_mode_r && stat.hb_hit)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      scan_mode_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= (state_nxt != S_IDLE);
      scan_mode_r <= scan_mode_nxt;
    end
  end

  assign busy = busy_r;

  // Commands to the datapath.
  always_comb begin
    cmd.tick       = is_tick;
    cmd.assign_w   = is_assign;
    cmd.hb_load    = is_hb;
    cmd.walk_start = go_walk;
    cmd.walking    = (state_r == S_WALK);
    cmd.scan_mode  = scan_mode_r;
  end

endmodule

// File: rtl/core/hbfd_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Heartbeat failure detector datapath
// Time counters, slot table memories, a one-slot-per-cycle walk pipeline and
// the result register with a one-deep pending stage for the last flag.
// ---------------------------------------------------------------------------
module hbfd_dp #(
  parameter int NODES   = hbfd_pkg::NODES_DEF,
  parameter int ID_BITS = hbfd_pkg::ID_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [7:0]                  in_node_id,
  input  logic [3:0]                  in_slot,
  input  hbfd_pkg::cfg_t              cfg,
  input  hbfd_pkg::dp_cmd_t           cmd,
  output hbfd_pkg::dp_stat_t          stat,
  output logic                        out_valid,
  output logic [3:0]                  out_slot_res,
  output logic [7:0]                  out_node_id_res,
  output logic                        out_new_status,
  output logic [hbfd_pkg::TIME_W-1:0] out_silent_ms,
  output logic                        out_last
);
  import hbfd_pkg::*;

  localparam int SLOT_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW0    = $clog2(NODES + 1);
  localparam int CW     = (CW0 > NC_W) ? CW0 : NC_W;

  // Time keeping.
  logic [TIME_W-1:0] now_r;
  logic [INT_W-1:0]  elapsed_r, el_inc, interval_eff;

  // Slot table.
  logic [ID_BITS-1:0] slot_ids_r   [NODES];
  logic [TIME_W-1:0]  last_heard_r [NODES];
  logic [NODES-1:0]   idv_r, heard_r, alive_r;

  // Walk pipeline.
  logic [CW-1:0]      idx_r, cnt, nc_x, slot_x;
  logic [SLOT_W-1:0]  rd_idx, ev_idx_r;
  logic               ev_vld_r, issue, walk_done;
  logic [ID_BITS-1:0] id_q_r, key_r, in_id_m, stored_id;
  logic [TIME_W-1:0]  lh_q_r, silent;
  logic               idv_q_r, heard_q_r, alive_q_r;
  logic               dead, chg, hit, flush, emit, slot_ok;

  // Pending change waiting to learn whether it is the last of its scan.
  logic               pend_vld_r;
  logic [3:0]         pend_slot_r;
  logic [7:0]         pend_id_r;
  logic               pend_stat_r;
  logic [TIME_W-1:0]  pend_sil_r;

  // Result register.
  logic               out_valid_r, out_last_r, out_stat_r;
  logic [3:0]         out_slot_r;
  logic [7:0]         out_id_r;
  logic [TIME_W-1:0]  out_sil_r;

  // Scan interval bookkeeping.
  assign el_inc       = elapsed_r + INT_W'(1);
  assign interval_eff = (cfg.interval == '0) ? INT_W'(1) : cfg.interval;

  // Slots in use and assign range check.
  assign nc_x    = CW'(cfg.node_count);
  assign cnt     = (nc_x > CW'(NODES)) ? CW'(NODES) : nc_x;
  assign slot_x  = CW'(in_slot);
  assign slot_ok = slot_x < CW'(NODES);
  assign in_id_m = ID_BITS'(in_node_id);

  // Issue one read per cycle; evaluate it in the next cycle.
  assign rd_idx    = idx_r[SLOT_W-1:0];
  assign issue     = cmd.walking && (idx_r < cnt);
  assign walk_done = (idx_r >= cnt) && !ev_vld_r;

  // Evaluation of the slot in the second stage.
  assign stored_id = idv_q_r ? id_q_r : '0;
  assign silent    = now_r - lh_q_r;
  assign dead      = silent > cfg.threshold;
  assign chg       = cmd.walking && cmd.scan_mode && ev_vld_r && heard_q_r &&
                     (alive_q_r == dead);
  assign hit       = cmd.walking && !cmd.scan_mode && ev_vld_r && (stored_id == key_r);
  assign flush     = cmd.walking && cmd.scan_mode && walk_done && pend_vld_r;
  assign emit      = (chg && pend_vld_r) || flush;

  always_comb begin
    stat.scan_due  = cfg.enable && (el_inc >= interval_eff);
    stat.walk_done = walk_done;
    stat.hb_hit    = hit;
  end

  // Id memory with registered read.
  always_ff @(posedge clk) begin
    if (cmd.assign_w && slot_ok) begin
      slot_ids_r[slot_x[SLOT_W-1:0]] <= in_id_m;
    end
    if (issue) begin
      id_q_r <= slot_ids_r[rd_idx];
    end
  end

  // Last-heard memory with registered read.
  always_ff @(posedge clk) begin
    if (hit) begin
      last_heard_r[ev_idx_r] <= now_r;
    end
    if (issue) begin
      lh_q_r <= last_heard_r[rd_idx];
    end
  end

  // Control state: counters, flags, walk pointer, pending and output strobes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      elapsed_r   <= '0;
      idv_r       <= '0;
      heard_r     <= '0;
      alive_r     <= '1;
      idx_r       <= '0;
      ev_vld_r    <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.tick) begin
        now_r <= now_r + TIME_W'(1);
        if (!cfg.enable || stat.scan_due) begin
          elapsed_r <= '0;
        end else begin
          elapsed_r <= el_inc;
        end
      end
      if (cmd.assign_w && slot_ok) begin
        idv_r[slot_x[SLOT_W-1:0]] <= 1'b1;
      end
      if (hit) begin
        heard_r[ev_idx_r] <= 1'b1;
      end
      if (chg) begin
        alive_r[ev_idx_r] <= !dead;
      end
      if (cmd.walk_start) begin
        idx_r <= '0;
      end else if (issue) begin
        idx_r <= idx_r + CW'(1);
      end
      ev_vld_r <= issue;
      if (cmd.walk_start || flush) begin
        pend_vld_r <= 1'b0;
      end else if (chg) begin
        pend_vld_r <= 1'b1;
      end
      out_valid_r <= emit;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.hb_load) begin
      key_r <= in_id_m;
    end
    if (issue) begin
      ev_idx_r  <= rd_idx;
      idv_q_r   <= idv_r[rd_idx];
      heard_q_r <= heard_r[rd_idx];
      alive_q_r <= alive_r[rd_idx];
    end
    if (chg) begin
      pend_slot_r <= 4'(ev_idx_r);
      pend_id_r   <= 8'(stored_id);
      pend_stat_r <= !dead;
      pend_sil_r  <= silent;
    end
    if (emit) begin
      out_slot_r <= pend_slot_r;
      out_id_r   <= pend_id_r;
      out_stat_r <= pend_stat_r;
      out_sil_r  <= pend_sil_r;
      out_last_r <= flush;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_slot_res    = out_slot_r;
  assign out_node_id_res = out_id_r;
  assign out_new_status  = out_stat_r;
  assign out_silent_ms   = out_sil_r;
  assign out_last        = out_last_r;

endmodule

// File: rtl/core/heartbeat_failure_detector_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Heartbeat failure detector
// Per-node liveness watchdog over a table of NODES slots.
//
//   Channel   Handshake                    Payload
//   input     start, busy (accept: start & !busy)
//                                          in_action, in_node_id, in_slot
//   result    out_valid (one-cycle strobe) out_slot_res, out_node_id_res,
//                                          out_new_status, out_silent_ms,
//                                          out_last
//   config    psel, penable, pwrite, pready
//                                          paddr, pwdata, prdata
//
// A tick without a scan, an assign and an unused action leave busy low. A
// heartbeat or a scan walks the slots in use one per cycle through the table
// memories' single read port while busy is high. Results of a scan follow the
// slot order; the last one is strobed in the first cycle in which busy is low
// again.
// Reset is synchronous; no clearing pass is needed.
// Results cannot be stalled by the receiver.
// ---------------------------------------------------------------------------
module heartbeat_failure_detector_top #(
  parameter int NODES   = hbfd_pkg::NODES_DEF,
  parameter int ID_BITS = hbfd_pkg::ID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_action,
  input  logic [7:0]                   in_node_id,
  input  logic [3:0]                   in_slot,
  output logic                         out_valid,
  output logic [3:0]                   out_slot_res,
  output logic [7:0]                   out_node_id_res,
  output logic                         out_new_status,
  output logic [hbfd_pkg::TIME_W-1:0]  out_silent_ms,
  output logic                         out_last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hbfd_pkg::PADDR_W-1:0] paddr,
  input  logic [hbfd_pkg::PDATA_W-1:0] pwdata,
  output logic [hbfd_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import hbfd_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Configuration registers.
  hbfd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer.
  hbfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .stat      (stat),
    .busy      (busy),
    .cmd       (cmd)
  );

  // Table and result datapath.
  hbfd_dp #(
    .NODES   (NODES),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_node_id      (in_node_id),
    .in_slot         (in_slot),
    .cfg             (cfg),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_slot_res    (out_slot_res),
    .out_node_id_res (out_node_id_res),
    .out_new_status  (out_new_status),
    .out_silent_ms   (out_silent_ms),
    .out_last        (out_last)
  );

endmodule

// File: rtl/core/hbfd_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Heartbeat failure detector port checker
// Checks the ordering of result strobes against busy and the last flag.
// ---------------------------------------------------------------------------
module hbfd_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic out_last
);

  // A result only comes out of a walk that was in progress.
  a_result_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  // A result that is not the last of its scan leaves the scan running.
  a_scan_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("non-final result while the block is idle");

  // The final result of a scan is never directly followed by another result.
  a_last_isolated: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result strobe right after the final result of a scan");

endmodule

bind heartbeat_failure_detector_top hbfd_checker u_hbfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid),
  .out_last  (out_last)
);
